### rtl/ttc_pkg.sv
package ttc_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int OUT_ONE          = 16384;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_LATCH,
    S_DET1,
    S_DET2,
    S_NUM1,
    S_NUM2,
    S_NUMSUB,
    S_CHECK,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_DONE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1
  } op_t;

endpackage

### rtl/ttc_store.sv
module ttc_store import ttc_pkg::*; #(
  parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
  parameter int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [159:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [159:0]  rdata
);

  logic [159:0] mem [VERTEX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ttc_isqrt.sv
module ttc_isqrt import ttc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [64:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= val;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[63:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/triangle_tangent_calc.sv
// Triangle tangent unit. An opcode 0 transaction writes one Q16.16 vertex
// (position and UV) into the vertex store and returns nothing, and loads can
// follow back to back. An opcode 1 transaction reads corners a, b and c and
// returns one Q2.14 unit tangent with a degenerate flag. The result is
// offered after store reads and product set-up, the numerators on the shared
// 33x33 multiplier, the checks and the scaling, the sum of the squares and a
// 32-step square root, and then three 45-step restoring divides. A degenerate
// triangle is offered straight after the checks.
// The block takes no new transaction until the result has been taken.
// Vertex store entries that were never written read back as undefined data.
module triangle_tangent_calc import ttc_pkg::*; #(
  parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic [9:0]         vertex_slot,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic [9:0]         index_a,
  input  logic [9:0]         index_b,
  input  logic [9:0]         index_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic               degenerate
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  state_t state, state_next;

  logic          in_acc;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [159:0]  rdata;
  logic [9:0]    ia, ib, ic;
  logic          va, vb, vc;
  logic [159:0]  vtx_a, vtx_b, vtx_c;

  // shared multiplier operands and product
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] acc;
  logic signed [66:0] det;
  logic signed [66:0] num [3];
  logic [1:0]         k;
  logic [65:0]        mag [3];
  logic               neg [3];
  logic [65:0]        orv;
  logic [6:0]         sh;
  logic [29:0]        m [3];
  logic [63:0]        sum;
  logic [59:0]        sq;
  logic [63:0]        sum_next;
  logic               sq_start, sq_done;
  logic [31:0]        root;
  logic [31:0]        len;
  logic [44:0]        drem;
  logic [44:0]        dquo;
  logic [5:0]         dcnt;
  logic [15:0]        q [3];
  logic [46:0]        dtrial;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign we       = in_acc && (opcode == 1'(OP_LOAD)) && ({22'd0, vertex_slot} < VERTEX_DEPTH);
  assign waddr    = AW'(vertex_slot);

  always_comb begin
    unique case (state)
      S_RD_A:  raddr = AW'(ia);
      S_RD_B:  raddr = AW'(ib);
      default: raddr = AW'(ic);
    endcase
  end

  ttc_store #(.VERTEX_DEPTH(VERTEX_DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({tex_v, tex_u, pos_z, pos_y, pos_x}),
    .raddr(raddr), .rdata(rdata)
  );

  ttc_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(sum_next), .done(sq_done), .root(root)
  );

  function automatic logic signed [32:0] fld(input logic [159:0] v, input int i);
    fld = {v[32*i+31], v[32*i +: 32]};
  endfunction

  logic signed [32:0] du1, dv1, du2, dv2, e1, e2;
  always_comb begin
    du1 = fld(vtx_b, 3) - fld(vtx_a, 3);
    dv1 = fld(vtx_b, 4) - fld(vtx_a, 4);
    du2 = fld(vtx_c, 3) - fld(vtx_a, 3);
    dv2 = fld(vtx_c, 4) - fld(vtx_a, 4);
    e1  = fld(vtx_b, 32'(k)) - fld(vtx_a, 32'(k));
    e2  = fld(vtx_c, 32'(k)) - fld(vtx_a, 32'(k));
  end

  always_comb begin
    unique case (state)
      S_DET1:  begin mul_a = du1; mul_b = dv2; end
      S_DET2:  begin mul_a = dv1; mul_b = du2; end
      S_NUM1:  begin mul_a = dv2; mul_b = e1;  end
      default: begin mul_a = dv1; mul_b = e2;  end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign orv      = mag[0] | mag[1] | mag[2];
  assign sq       = m[k] * m[k];
  assign sum_next = sum + 64'(sq);
  assign dtrial   = {1'b0, drem, dquo[44]} - {15'd0, len};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_acc && opcode == 1'(OP_TRI)) state_next = S_RD_A;
      S_RD_A:     state_next = S_RD_B;
      S_RD_B:     state_next = S_RD_C;
      S_RD_C:     state_next = S_LATCH;
      S_LATCH:    state_next = S_DET1;
      S_DET1:     state_next = S_DET2;
      S_DET2:     state_next = S_NUM1;
      S_NUM1:     state_next = S_NUM2;
      S_NUM2:     state_next = S_NUMSUB;
      S_NUMSUB:   state_next = (k == 2'd2) ? S_CHECK : S_NUM1;
      S_CHECK:    state_next = (det == '0 || orv == '0) ? S_OUT : S_NORM;
      S_NORM:     state_next = S_SQ;
      S_SQ:       state_next = (k == 2'd2) ? S_SQRT : S_SQ;
      S_SQRT:     if (sq_done) state_next = (root == '0) ? S_OUT : S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (dcnt == 6'd0) state_next = S_DIV_DONE;
      S_DIV_DONE: state_next = (k == 2'd2) ? S_OUT : S_DIV_INIT;
      S_OUT:      if (!out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sq_start  = (state == S_SQ) && (k == 2'd2);
    out_valid = (state == S_OUT);
  end

  logic [6:0]  bl;
  always_comb begin
    bl = '0;
    for (int i = 0; i < 66; i++) begin
      if (orv[i]) bl = 7'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ia <= index_a; ib <= index_b; ic <= index_c;
        k  <= '0;
      end
      S_RD_B: begin
        vtx_a <= va ? rdata : '0;
      end
      S_RD_C: begin
        vtx_b <= vb ? rdata : '0;
      end
      S_LATCH: begin
        vtx_c <= vc ? rdata : '0;
      end
      S_DET2: acc <= 67'(prod);
      S_NUM1: begin
        if (k == 2'd0) det <= acc - 67'(prod);
      end
      S_NUM2: acc <= 67'(prod);
      S_NUMSUB: begin
        num[k] <= acc - 67'(prod);
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      S_CHECK: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= num[i][66] ^ det[66];
        end
        sh <= (bl > 7'd30) ? bl - 7'd30 : 7'd0;
        sum <= '0;
        degenerate <= 1'b1;
        tangent_x <= '0; tangent_y <= '0; tangent_z <= '0;
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) m[i] <= 30'(mag[i] >> sh);
      end
      S_SQ: begin
        sum <= sum_next;
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      S_SQRT: len <= root;
      S_DIV_INIT: begin
        // dividend m*16384 + len/2
        dquo <= 45'({m[k], 14'd0}) + 45'(len >> 1);
        drem <= '0;
        dcnt <= 6'd44;
      end
      S_DIV: begin
        if (!dtrial[46]) begin
          drem <= dtrial[44:0];
          dquo <= {dquo[43:0], 1'b1};
        end else begin
          drem <= {drem[43:0], dquo[44]};
          dquo <= {dquo[43:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
      end
      S_DIV_DONE: begin
        q[k] <= (dquo > 45'(OUT_ONE)) ? 16'(OUT_ONE) : 16'(dquo);
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        if (k == 2'd2) begin
          degenerate <= 1'b0;
          tangent_x <= neg[0] ? -q[0] : q[0];
          tangent_y <= neg[1] ? -q[1] : q[1];
          tangent_z <= neg[2] ? -((dquo > 45'(OUT_ONE)) ? 16'(OUT_ONE) : 16'(dquo))
                              : ((dquo > 45'(OUT_ONE)) ? 16'(OUT_ONE) : 16'(dquo));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    va = ({22'd0, ia} < VERTEX_DEPTH);
    vb = ({22'd0, ib} < VERTEX_DEPTH);
    vc = ({22'd0, ic} < VERTEX_DEPTH);
    for (int i = 0; i < 3; i++) begin
      mag[i] = num[i][66] ? 66'(-num[i]) : 66'(num[i]);
    end
  end

endmodule
